// ===== rtl/ydp_pkg.sv =====
// Shared types, constants and small arithmetic helpers for the pixel deinterlacer.
// No dependencies; used by ydp_temporal, ydp_spatial and yadif_deinterlace_pixel_top.
package ydp_pkg;

   // Significant pixel width (8..16); the port fields stay 16 bits wide.
   localparam int PIXEL_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int TRIO_BITS   = 3 * FIELD_BITS;
   localparam int SPREAD_BITS = PIXEL_BITS + 1;
   localparam int SCORE_BITS  = PIXEL_BITS + 2;
   localparam int SGN_BITS    = PIXEL_BITS + 3;

   localparam int WIN_DEPTH   = 7;
   localparam int WIN_CENTER  = 3;
   localparam int DLY_DEPTH   = 3;
   localparam int FILL_FULL   = 3;
   localparam int FLUSH_PUSHES = 3;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPATIAL_CHECK = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTERNAL_PRED = 1'd1;

   typedef logic [PIXEL_BITS-1:0]          pix_type;
   typedef logic [SPREAD_BITS-1:0]         spread_type;
   typedef logic [SCORE_BITS-1:0]          score_type;
   typedef logic signed [SGN_BITS-1:0]     sgn_type;
   typedef pix_type [WIN_DEPTH-1:0]        pix_win_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] cur_above;
      logic [FIELD_BITS-1:0] cur_below;
      logic [FIELD_BITS-1:0] prev_above;
      logic [FIELD_BITS-1:0] prev_below;
      logic [FIELD_BITS-1:0] next_above;
      logic [FIELD_BITS-1:0] next_below;
      logic [TRIO_BITS-1:0]  match_prev_trio;
      logic [TRIO_BITS-1:0]  match_next_trio;
      logic [FIELD_BITS-1:0] ext_pred;
      logic                  line_end;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] out_pixel;
      logic                  out_last;
   } rsp_type;

   // Temporal result of one column
   typedef struct packed {
      pix_type    centre;
      spread_type spread;
   } tmp_type;

   // Everything the output stage needs besides the window
   typedef struct packed {
      pix_type    centre;
      spread_type spread;
      pix_type    ext;
      logic       ext_on;
      logic       last;
   } eval_type;

   function automatic pix_type abs_diff(input pix_type a, input pix_type b);
      return (a > b) ? pix_type'(a - b) : pix_type'(b - a);
   endfunction

   function automatic pix_type avg2(input pix_type a, input pix_type b);
      logic [PIXEL_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[PIXEL_BITS:1];
   endfunction

   function automatic sgn_type smax(input sgn_type a, input sgn_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic sgn_type smin(input sgn_type a, input sgn_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic sgn_type to_sgn(input pix_type a);
      return sgn_type'({3'b000, a});
   endfunction

endpackage

// ===== rtl/ydp_temporal.sv =====
// Temporal centre and allowed spread of one pixel column, with optional spatial check.
// Depends on ydp_pkg.
module ydp_temporal (
   input  ydp_pkg::req_type item,
   input  logic             spatial_check_on,
   output ydp_pkg::tmp_type tmp
);

   ydp_pkg::pix_type p1, p3, pa, pb, na, nb;
   ydp_pkg::pix_type mpa, mpc, mpb, mna, mnc, mnb;
   ydp_pkg::pix_type centre, d0, d1, d2, diff;
   logic [ydp_pkg::PIXEL_BITS:0] sum1, sum2;
   ydp_pkg::sgn_type e0, e1, e3, e4, mx, mn, chk;

   always_comb begin
      p1  = item.cur_above[ydp_pkg::PIXEL_BITS-1:0];
      p3  = item.cur_below[ydp_pkg::PIXEL_BITS-1:0];
      pa  = item.prev_above[ydp_pkg::PIXEL_BITS-1:0];
      pb  = item.prev_below[ydp_pkg::PIXEL_BITS-1:0];
      na  = item.next_above[ydp_pkg::PIXEL_BITS-1:0];
      nb  = item.next_below[ydp_pkg::PIXEL_BITS-1:0];
      mpa = item.match_prev_trio[0*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];
      mpc = item.match_prev_trio[1*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];
      mpb = item.match_prev_trio[2*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];
      mna = item.match_next_trio[0*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];
      mnc = item.match_next_trio[1*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];
      mnb = item.match_next_trio[2*ydp_pkg::FIELD_BITS +: ydp_pkg::PIXEL_BITS];

      centre = ydp_pkg::avg2(mpc, mnc);
      d0     = ydp_pkg::abs_diff(mpc, mnc) >> 1;
      sum1   = {1'b0, ydp_pkg::abs_diff(pa, p1)} + {1'b0, ydp_pkg::abs_diff(pb, p3)};
      sum2   = {1'b0, ydp_pkg::abs_diff(na, p1)} + {1'b0, ydp_pkg::abs_diff(nb, p3)};
      d1     = sum1[ydp_pkg::PIXEL_BITS:1];
      d2     = sum2[ydp_pkg::PIXEL_BITS:1];
      diff   = (d0 > d1) ? d0 : d1;
      diff   = (diff > d2) ? diff : d2;

      // spatial check: widen by how far the centre sits outside the vertical trend
      e1  = ydp_pkg::to_sgn(centre) - ydp_pkg::to_sgn(p1);
      e3  = ydp_pkg::to_sgn(centre) - ydp_pkg::to_sgn(p3);
      e0  = ydp_pkg::to_sgn(ydp_pkg::avg2(mpa, mna)) - ydp_pkg::to_sgn(p1);
      e4  = ydp_pkg::to_sgn(ydp_pkg::avg2(mpb, mnb)) - ydp_pkg::to_sgn(p3);
      mx  = ydp_pkg::smax(ydp_pkg::smax(e1, e3), ydp_pkg::smin(e0, e4));
      mn  = ydp_pkg::smin(ydp_pkg::smin(e1, e3), ydp_pkg::smax(e0, e4));
      chk = ydp_pkg::smax(ydp_pkg::smax(ydp_pkg::to_sgn(diff), mn), -mx);

      tmp.centre = centre;
      tmp.spread = spatial_check_on ? chk[ydp_pkg::SPREAD_BITS-1:0]
                                    : ydp_pkg::spread_type'(diff);
   end

endmodule

// ===== rtl/ydp_spatial.sv =====
// Edge-directed spatial prediction over the 7-wide window and final clamp.
// Depends on ydp_pkg.
module ydp_spatial (
   input  ydp_pkg::pix_win_type win_above,
   input  ydp_pkg::pix_win_type win_below,
   input  ydp_pkg::eval_type    eval,
   output ydp_pkg::pix_type     pixel
);

   // sum of three abs diffs along direction n, around the window center
   function automatic ydp_pkg::sgn_type dir_score(input ydp_pkg::pix_win_type a,
                                                  input ydp_pkg::pix_win_type b,
                                                  input int n);
      ydp_pkg::score_type s;
      s = '0;
      for (int k = -1; k <= 1; k++) begin
         s = s + ydp_pkg::score_type'(ydp_pkg::abs_diff(a[ydp_pkg::WIN_CENTER + k + n],
                                                        b[ydp_pkg::WIN_CENTER + k - n]));
      end
      return ydp_pkg::sgn_type'({1'b0, s});
   endfunction

   ydp_pkg::sgn_type s_m2, s_m1, s_p1, s_p2, best, lo, hi, v;
   ydp_pkg::pix_type pred, sp;

   always_comb begin
      s_m2 = dir_score(win_above, win_below, -2);
      s_m1 = dir_score(win_above, win_below, -1);
      s_p1 = dir_score(win_above, win_below, 1);
      s_p2 = dir_score(win_above, win_below, 2);

      // vertical wins ties: its score is biased down by one
      best = dir_score(win_above, win_below, 0) - ydp_pkg::sgn_type'(1);
      pred = ydp_pkg::avg2(win_above[3], win_below[3]);
      if (s_m1 < best) begin
         best = s_m1;
         pred = ydp_pkg::avg2(win_above[2], win_below[4]);
         if (s_m2 < best) begin
            best = s_m2;
            pred = ydp_pkg::avg2(win_above[1], win_below[5]);
         end
      end
      if (s_p1 < best) begin
         best = s_p1;
         pred = ydp_pkg::avg2(win_above[4], win_below[2]);
         if (s_p2 < best) begin
            pred = ydp_pkg::avg2(win_above[5], win_below[1]);
         end
      end

      sp = eval.ext_on ? eval.ext : pred;
      lo = ydp_pkg::to_sgn(eval.centre) - ydp_pkg::sgn_type'({2'b00, eval.spread});
      hi = ydp_pkg::to_sgn(eval.centre) + ydp_pkg::sgn_type'({2'b00, eval.spread});
      v  = ydp_pkg::smin(ydp_pkg::smax(ydp_pkg::to_sgn(sp), lo), hi);
      pixel = v[ydp_pkg::PIXEL_BITS-1:0];
   end

endmodule

// ===== rtl/yadif_deinterlace_pixel_top.sv =====
// Top level of the pixel deinterlacer: input register, column push engine, output stages.
// Depends on ydp_pkg, ydp_temporal and ydp_spatial.
//
// Usage:
//  - req channel (valid/ready): one item per pixel column of the missing line, with the
//    current-field, previous/next-frame and field-match pixels. line_end marks the last
//    column of a line.
//  - rsp channel (valid/ready): one reconstructed pixel per column, in column order;
//    out_last is set on the last pixel of each line.
//  - csr port: write-only, index 0 = spatial check enable, index 1 = external prediction
//    select. Write only while the block is idle.
//  - Throughput: one item per clock mid-line while rsp is not held off. After an item with
//    line_end, three right-edge replica columns are pushed through the window (input held off).
//  - Result path: a result needs the three following columns; once its third successor has
//    been accepted, the pixel goes through the push into the window, then the output register.
//    The last pixel of a line follows the line_end item through its push, three flush pushes
//    and the output register.
//  - Reset: synchronous, clears all valids, line fill and flush state, and loads the
//    config defaults (spatial check on, external prediction off).
//  - Stall: when rsp is held off and the evaluation stage holds a column, that stage and the
//    window freeze; one more item can still be taken into the input register.
module yadif_deinterlace_pixel_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ydp_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ydp_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [ydp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ydp_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // config
   logic spatial_check_ff, ext_pred_on_ff;

   // input register
   logic             a_valid_ff, a_valid_in;
   ydp_pkg::req_type a_ff;

   // column window and delay lines for the temporal values
   ydp_pkg::pix_win_type win_above_ff, win_above_in, win_below_ff, win_below_in;
   ydp_pkg::pix_type     [ydp_pkg::DLY_DEPTH-1:0] cdly_ff, cdly_in, edly_ff, edly_in;
   ydp_pkg::spread_type  [ydp_pkg::DLY_DEPTH-1:0] sdly_ff, sdly_in;
   logic [1:0]           fill_ff, fill_in;
   logic [1:0]           flush_cnt_ff, flush_cnt_in;

   // evaluation register (one column whose window is complete)
   logic              b_valid_ff, b_valid_in;
   ydp_pkg::eval_type b_ff, b_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   ydp_pkg::rsp_type rsp_ff;

   ydp_pkg::tmp_type tmp;
   ydp_pkg::pix_type eval_pixel;
   ydp_pkg::pix_type push_above, push_below, push_centre, push_ext;
   ydp_pkg::spread_type push_spread;
   logic out_can_load, b_move, b_free, flushing, push_en, last_flush;

   ydp_temporal u_temporal (
      .item             (a_ff),
      .spatial_check_on (spatial_check_ff),
      .tmp              (tmp)
   );

   ydp_spatial u_spatial (
      .win_above (win_above_ff),
      .win_below (win_below_ff),
      .eval      (b_ff),
      .pixel     (eval_pixel)
   );

   // handshake and push control
   always_comb begin
      out_can_load = !rsp_valid_ff || rsp_ready;
      b_move       = b_valid_ff && out_can_load;
      b_free       = !b_valid_ff || out_can_load;
      flushing     = (flush_cnt_ff != 2'd0);
      last_flush   = (flush_cnt_ff == 2'd1);
      // the window may move only when the evaluation stage can take its column
      push_en      = b_free && (flushing || a_valid_ff);
      req_ready    = !a_valid_ff || (push_en && !flushing);
      a_valid_in   = (req_valid && req_ready) || (a_valid_ff && !(push_en && !flushing));
   end

   // column push: new item, or a right-edge replica during the line-end flush
   always_comb begin
      push_above   = flushing ? win_above_ff[ydp_pkg::WIN_DEPTH-1]
                              : a_ff.cur_above[ydp_pkg::PIXEL_BITS-1:0];
      push_below   = flushing ? win_below_ff[ydp_pkg::WIN_DEPTH-1]
                              : a_ff.cur_below[ydp_pkg::PIXEL_BITS-1:0];
      push_centre  = flushing ? '0 : tmp.centre;
      push_spread  = flushing ? '0 : tmp.spread;
      push_ext     = flushing ? '0 : a_ff.ext_pred[ydp_pkg::PIXEL_BITS-1:0];

      win_above_in = win_above_ff;
      win_below_in = win_below_ff;
      cdly_in      = cdly_ff;
      sdly_in      = sdly_ff;
      edly_in      = edly_ff;
      fill_in      = fill_ff;
      flush_cnt_in = flush_cnt_ff;
      b_valid_in   = b_valid_ff && !b_move;
      b_in         = b_ff;

      if (push_en) begin
         if (fill_ff == 2'd0) begin
            // line start: left edge replicates the first column
            for (int i = 0; i < ydp_pkg::WIN_DEPTH; i++) begin
               win_above_in[i] = push_above;
               win_below_in[i] = push_below;
            end
         end else begin
            for (int i = 0; i < ydp_pkg::WIN_DEPTH - 1; i++) begin
               win_above_in[i] = win_above_ff[i+1];
               win_below_in[i] = win_below_ff[i+1];
            end
            win_above_in[ydp_pkg::WIN_DEPTH-1] = push_above;
            win_below_in[ydp_pkg::WIN_DEPTH-1] = push_below;
         end
         for (int i = 0; i < ydp_pkg::DLY_DEPTH - 1; i++) begin
            cdly_in[i] = cdly_ff[i+1];
            sdly_in[i] = sdly_ff[i+1];
            edly_in[i] = edly_ff[i+1];
         end
         cdly_in[ydp_pkg::DLY_DEPTH-1] = push_centre;
         sdly_in[ydp_pkg::DLY_DEPTH-1] = push_spread;
         edly_in[ydp_pkg::DLY_DEPTH-1] = push_ext;

         if (fill_ff == 2'(ydp_pkg::FILL_FULL)) begin
            b_valid_in  = 1'b1;
            b_in.centre = cdly_ff[0];
            b_in.spread = sdly_ff[0];
            b_in.ext    = edly_ff[0];
            b_in.ext_on = ext_pred_on_ff;
            b_in.last   = flushing && last_flush;
         end else begin
            fill_in = fill_ff + 2'd1;
         end

         if (flushing) begin
            flush_cnt_in = flush_cnt_ff - 2'd1;
            if (last_flush) begin
               fill_in = '0;
            end
         end else if (a_ff.line_end) begin
            flush_cnt_in = 2'(ydp_pkg::FLUSH_PUSHES);
         end
      end

      rsp_valid_in = b_move || (rsp_valid_ff && !rsp_ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         spatial_check_ff <= 1'b1;
         ext_pred_on_ff   <= 1'b0;
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         fill_ff          <= '0;
         flush_cnt_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ydp_pkg::CSR_SPATIAL_CHECK: spatial_check_ff <= csr_data[0];
               ydp_pkg::CSR_EXTERNAL_PRED: ext_pred_on_ff   <= csr_data[0];
            endcase
         end
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         flush_cnt_ff <= flush_cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_ff <= req_payload;
      end
      win_above_ff <= win_above_in;
      win_below_ff <= win_below_in;
      cdly_ff      <= cdly_in;
      sdly_ff      <= sdly_in;
      edly_ff      <= edly_in;
      b_ff         <= b_in;
      if (b_move) begin
         rsp_ff.out_pixel <= ydp_pkg::FIELD_BITS'(eval_pixel);
         rsp_ff.out_last  <= b_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a push into a window that is not yet full never loads the evaluation stage
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      push_en && (fill_ff != 2'(ydp_pkg::FILL_FULL)) |=> !b_valid_ff)
      else $error("result produced before window filled");

   // the final flush push always has a full window, so every line ends with a result
   a_last_flush_full: assert property (@(posedge clock) disable iff (reset)
      push_en && last_flush |-> fill_ff == 2'(ydp_pkg::FILL_FULL))
      else $error("line end flush without full window");

   // while the last pixel of a line waits, the line state is already cleared
   a_last_clears_line: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_ff.last |-> (fill_ff == 2'd0) && (flush_cnt_ff == 2'd0))
      else $error("line state not cleared at last pixel");

   // the flush runs only on a started line
   a_flush_on_line: assert property (@(posedge clock) disable iff (reset)
      flushing |-> fill_ff != 2'd0)
      else $error("flush with empty window");

endmodule
